/* src/hop_count_route_table_macros.svh */
// ----------------------------------------------------------------------------
// Route table check macros
// Concurrent property wrappers used by the route table RTL.
// ----------------------------------------------------------------------------
`ifndef HOP_COUNT_ROUTE_TABLE_MACROS_SVH
`define HOP_COUNT_ROUTE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HCRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HCRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hcrt_pkg.sv */
// ----------------------------------------------------------------------------
// Route table package
// Beat types, entry layout and reset constants for the route table.
// ----------------------------------------------------------------------------
package hcrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam logic [31:0] MAX_ROUTE_AGE_RST = 32'd300000;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [7:0]        node_id;
        logic [7:0]        hop_count;
        logic signed [7:0] signal_strength;
        logic [31:0]       now_ms;
    } route_req_t;

    typedef struct packed {
        logic              route_found;
        logic [7:0]        route_hops;
        logic signed [7:0] route_signal;
        logic [31:0]       route_time;
        logic              changed;
        logic              dropped;
        logic [4:0]        entries_used;
    } route_rsp_t;

    typedef struct packed {
        logic [7:0]        node;
        logic [7:0]        hops;
        logic signed [7:0] sig;
        logic [31:0]       stamp;
    } route_entry_t;

endpackage

/* src/hop_count_route_table.sv */
// A request beat passes the SCAN, DECIDE and OUT states in order; SCAN reads the N
// entries in use (N = 0..TABLE_ENTRIES) one entry a cycle and stops on the first id match.
// One request at a time: req_stall stays high from the accepted beat until the response
// beat has been taken.
// Reset: rst_n clears the entry count, the sequencer and sets max_route_age to 300000;
// table contents are not cleared, entries at or above the count are never read.
// ----------------------------------------------------------------------------
// Hop count route table
// Keeps one route per node id (hops, signal, last update time). Update beats
// insert or improve a route, lookup beats return a route that is still fresh.
// ----------------------------------------------------------------------------
module hop_count_route_table #(
    parameter int TABLE_ENTRIES = hcrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    // configuration: max_route_age
    input  logic               age_we,
    input  logic [31:0]        age_data,

    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  hcrt_pkg::route_req_t req_data,

    // response channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output hcrt_pkg::route_rsp_t rsp_data
);

    import hcrt_pkg::*;

    // Index width addresses the table; count width also holds the full count.
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      age_reg;

    // Scan pointer and compare stage
    logic [CNT_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic             hit_reg;
    route_entry_t     rd_data_reg;

    // Latched request and registered response
    route_req_t       item_reg;
    route_rsp_t       rsp_reg, rsp_next;

    // Table memory, one write port and one registered read port
    route_entry_t     entry_mem [TABLE_ENTRIES];

    logic             req_take;
    logic             id_match;
    logic             more_to_read;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    route_entry_t     wr_entry;
    logic [31:0]      route_age;
    logic             fresh;
    logic             better;
    logic             has_room;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = (state_reg == ST_OUT);
    assign rsp_data  = rsp_reg;

    // ------------------------------------------------------------------
    // Scan: the one comparator checks the entry read in the previous cycle
    // while the next entry is read. Stop on the first id match or when
    // every entry below the count has been compared.
    // ------------------------------------------------------------------
    assign id_match     = cmp_vld_reg && (rd_data_reg.node == item_reg.node_id);
    assign more_to_read = (rd_idx_reg < cnt_reg);
    assign rd_en        = (state_reg == ST_SCAN) && !id_match && more_to_read;

    // ------------------------------------------------------------------
    // Decide: age check for lookups, route preference for updates.
    // On a hit rd_data_reg still holds the matching entry.
    // ------------------------------------------------------------------
    assign route_age = item_reg.now_ms - rd_data_reg.stamp;
    assign fresh     = (route_age < age_reg);
    assign better    = (item_reg.hop_count < rd_data_reg.hops) ||
                       ((item_reg.hop_count == rd_data_reg.hops) &&
                        ($signed(item_reg.signal_strength) > $signed(rd_data_reg.sig)));
    assign has_room  = (cnt_reg < CNT_W'(TABLE_ENTRIES));

    always_comb
    begin
        wr_entry.node  = item_reg.node_id;
        wr_entry.hops  = item_reg.hop_count;
        wr_entry.sig   = item_reg.signal_strength;
        wr_entry.stamp = item_reg.now_ms;

        wr_en    = 1'b0;
        wr_idx   = cmp_idx_reg;
        cnt_next = cnt_reg;
        rsp_next = '0;

        if (item_reg.operation == OP_UPDATE)
        begin
            if (hit_reg)
            begin
                rsp_next.route_found = 1'b1;
                if (better)
                begin
                    // overwrite the existing route in place
                    wr_en                 = 1'b1;
                    rsp_next.changed      = 1'b1;
                    rsp_next.route_hops   = wr_entry.hops;
                    rsp_next.route_signal = wr_entry.sig;
                    rsp_next.route_time   = wr_entry.stamp;
                end
                else
                begin
                    rsp_next.route_hops   = rd_data_reg.hops;
                    rsp_next.route_signal = rd_data_reg.sig;
                    rsp_next.route_time   = rd_data_reg.stamp;
                end
            end
            else if (has_room)
            begin
                // append behind the last valid entry
                wr_en                 = 1'b1;
                wr_idx                = cnt_reg[IDX_W-1:0];
                cnt_next              = cnt_reg + CNT_W'(1);
                rsp_next.changed      = 1'b1;
                rsp_next.route_hops   = wr_entry.hops;
                rsp_next.route_signal = wr_entry.sig;
                rsp_next.route_time   = wr_entry.stamp;
            end
            else
            begin
                // table full: drop the beat
                rsp_next.dropped = 1'b1;
            end
        end
        else if (hit_reg && fresh)
        begin
            rsp_next.route_found  = 1'b1;
            rsp_next.route_hops   = rd_data_reg.hops;
            rsp_next.route_signal = rd_data_reg.sig;
            rsp_next.route_time   = rd_data_reg.stamp;
        end

        rsp_next.entries_used = 5'(cnt_next);

        if (state_reg != ST_DECIDE)
        begin
            wr_en    = 1'b0;
            cnt_next = cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (id_match || !more_to_read)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            age_reg     <= MAX_ROUTE_AGE_RST;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (age_we)
            begin
                age_reg <= age_data;
            end

            if (req_take)
            begin
                // restart the scan from entry zero
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (id_match)
                begin
                    hit_reg     <= 1'b1;
                    cmp_vld_reg <= 1'b0;
                end
                else if (more_to_read)
                begin
                    rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
                    cmp_vld_reg <= 1'b1;
                end
                else
                begin
                    cmp_vld_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers: hold the request, advance the compare index, load the response
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg <= req_data;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (state_reg == ST_DECIDE)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`include "hop_count_route_table_macros.svh"

    `HCRT_ASSERT_NEXT(a_cnt_moves_in_decide, state_reg != ST_DECIDE, $stable(cnt_reg),
        "entry count changed outside decide")
    `HCRT_ASSERT_NOW(a_no_take_while_busy, rsp_valid, req_stall,
        "request taken while a response is pending")
    `HCRT_ASSERT_NOW(a_drop_only_when_full, rsp_valid && rsp_data.dropped,
        (cnt_reg == CNT_W'(TABLE_ENTRIES)) && !rsp_data.changed && !rsp_data.route_found,
        "drop flagged with room left")
    `HCRT_ASSERT_NOW(a_hit_below_count, (state_reg == ST_DECIDE) && hit_reg,
        CNT_W'(cmp_idx_reg) < cnt_reg, "hit on an entry beyond the count")
    `HCRT_ASSERT_NEXT(a_one_hop_append, (state_reg == ST_DECIDE) && (cnt_next != cnt_reg),
        cnt_reg == $past(cnt_reg) + CNT_W'(1), "entry count grew by more than one")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route table testbench
// Sends update and lookup beats to the route table with random gaps and
// response stalls. It mirrors the table to predict each response and
// compares every field. The age limit is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
    import hcrt_pkg::*;

    localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int RANDOM_PHASES  = 5;
    localparam int MAX_WAIT       = 12;
    // Worst scan latency plus margin, used for the drain at the end.
    localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 3 + 8;
    // Far above the slowest correct beat: longest gap, worst scan latency and longest stall.
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum logic {ROW_BEAT, ROW_AGE} row_kind_t;

    // One row of the directed table: either an age write or a request beat,
    // optionally with the response typed in by hand.
    typedef struct {
        row_kind_t   kind;
        logic [31:0] age;
        route_req_t  req;
        bit          typed;
        route_rsp_t  rsp;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       age_we;
    logic [31:0] age_data;
    logic       req_valid;
    logic       req_stall;
    route_req_t req_data;
    logic       rsp_valid;
    logic       rsp_stall;
    route_rsp_t rsp_data;

    // Mirror of the table contents, entry count and age limit.
    route_entry_t route_mirror [TABLE_ENTRIES];
    int           mirror_count;
    logic [31:0]  mirror_age;

    route_rsp_t   expected_rsp_q [$];
    stim_row_t    directed_rows [$];
    int unsigned  err_count = 0;
    int unsigned  rsp_count = 0;
    bit           send_burst = 1'b0;
    bit           recv_burst = 1'b0;
    logic [31:0]  ms_clock;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hop_count_route_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .age_we    (age_we),
        .age_data  (age_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // ------------------------------------------------------------------
    // Route prediction: search the mirror, apply the update or the
    // freshness test, and build the response the block should return.
    // ------------------------------------------------------------------
    function automatic route_rsp_t predict_route_rsp(input route_req_t beat);
        int          i;
        int          slot;
        int          shown;
        logic [31:0] age;
        route_rsp_t  rsp;
        slot  = -1;
        shown = -1;
        rsp   = '0;
        // Ids are unique, so the first match is the only one.
        for (i = 0; i < mirror_count; i++)
        begin
            if (slot < 0 && route_mirror[i].node == beat.node_id)
                slot = i;
        end
        if (beat.operation == OP_UPDATE)
        begin
            if (slot >= 0)
            begin
                rsp.route_found = 1'b1;
                // Improve only on fewer hops, or equal hops and a strictly
                // stronger signal.
                if (beat.hop_count < route_mirror[slot].hops ||
                    (beat.hop_count == route_mirror[slot].hops &&
                     $signed(beat.signal_strength) > $signed(route_mirror[slot].sig)))
                begin
                    route_mirror[slot].hops  = beat.hop_count;
                    route_mirror[slot].sig   = beat.signal_strength;
                    route_mirror[slot].stamp = beat.now_ms;
                    rsp.changed = 1'b1;
                end
                shown = slot;
            end
            else if (mirror_count < TABLE_ENTRIES)
            begin
                route_mirror[mirror_count].node  = beat.node_id;
                route_mirror[mirror_count].hops  = beat.hop_count;
                route_mirror[mirror_count].sig   = beat.signal_strength;
                route_mirror[mirror_count].stamp = beat.now_ms;
                shown = mirror_count;
                mirror_count++;
                rsp.changed = 1'b1;
            end
            else
            begin
                rsp.dropped = 1'b1;
            end
        end
        else if (slot >= 0)
        begin
            // Age wraps modulo 2^32.
            age = beat.now_ms - route_mirror[slot].stamp;
            if (age < mirror_age)
            begin
                rsp.route_found = 1'b1;
                shown = slot;
            end
        end
        if (shown >= 0)
        begin
            rsp.route_hops   = route_mirror[shown].hops;
            rsp.route_signal = route_mirror[shown].sig;
            rsp.route_time   = route_mirror[shown].stamp;
        end
        rsp.entries_used = 5'(mirror_count);
        return rsp;
    endfunction

    function automatic route_req_t mk_req(input logic op, input logic [7:0] node,
                                          input logic [7:0] hops, input logic [7:0] sig,
                                          input logic [31:0] now);
        route_req_t r;
        r.operation       = op;
        r.node_id         = node;
        r.hop_count       = hops;
        r.signal_strength = sig;
        r.now_ms          = now;
        return r;
    endfunction

    function automatic route_rsp_t mk_rsp(input logic found, input logic [7:0] hops,
                                          input logic [7:0] sig, input logic [31:0] stamp,
                                          input logic chg, input logic drop,
                                          input logic [4:0] used);
        route_rsp_t r;
        r.route_found  = found;
        r.route_hops   = hops;
        r.route_signal = sig;
        r.route_time   = stamp;
        r.changed      = chg;
        r.dropped      = drop;
        r.entries_used = used;
        return r;
    endfunction

    task automatic add_beat(input route_req_t req, input bit typed, input route_rsp_t rsp);
        stim_row_t row;
        row.kind  = ROW_BEAT;
        row.age   = '0;
        row.req   = req;
        row.typed = typed;
        row.rsp   = rsp;
        directed_rows.push_back(row);
    endtask

    task automatic add_age(input logic [31:0] value);
        stim_row_t row;
        row.kind  = ROW_AGE;
        row.age   = value;
        row.req   = '0;
        row.typed = 1'b0;
        row.rsp   = '0;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d %s got 0x%0h expected 0x%0h",
                                      rsp_count, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Request driver: idle for a drawn gap, present the beat, hold it until
    // accepted, then predict and queue its response.
    // ------------------------------------------------------------------
    task automatic send_beat(input route_req_t beat, input bit typed,
                             input route_rsp_t typed_rsp);
        int         gap;
        route_rsp_t pred;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        do
            @(posedge clk);
        while (req_stall);
        // Keep the mirror moving even where the response is typed in.
        pred = predict_route_rsp(beat);
        expected_rsp_q.push_back(typed ? typed_rsp : pred);
        if ($urandom_range(0, 63) == 0)
            send_burst = !send_burst;
    endtask

    // ------------------------------------------------------------------
    // Age limit write: drop valid, wait until every response is back so the
    // block is idle, then pulse the write enable for one cycle.
    // ------------------------------------------------------------------
    task automatic write_age(input logic [31:0] value);
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        age_we   <= 1'b1;
        age_data <= value;
        @(posedge clk);
        age_we   <= 1'b0;
        mirror_age = value;
    endtask

    // ------------------------------------------------------------------
    // Response receiver: stall for a drawn number of cycles, then release
    // and wait for the next beat. Burst mode turns stalling off for a while.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rsp_valid && !rsp_stall));
            if ($urandom_range(0, 63) == 0)
                recv_burst = !recv_burst;
        end
    end

    // ------------------------------------------------------------------
    // Response checker: compare each accepted beat with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        route_rsp_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                report_mismatch($sformatf("response %0d arrived with none pending",
                                          rsp_count));
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("route_found",  rsp_data.route_found,  want.route_found);
                check_field("route_hops",   rsp_data.route_hops,   want.route_hops);
                check_field("route_signal", {24'd0, rsp_data.route_signal},
                            {24'd0, want.route_signal});
                check_field("route_time",   rsp_data.route_time,   want.route_time);
                check_field("changed",      rsp_data.changed,      want.changed);
                check_field("dropped",      rsp_data.dropped,      want.dropped);
                check_field("entries_used", rsp_data.entries_used, want.entries_used);
            end
            rsp_count++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either channel for too long.
    // ------------------------------------------------------------------
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                (rsp_valid === 1'b1 && rsp_stall === 1'b0) || age_we === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain.
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] phase_age [RANDOM_PHASES];
        route_req_t  beat;
        int          node_n;
        int          phase;
        int          n;
        int          pick;
        int          roll;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        age_we    <= 1'b0;
        age_data  <= '0;
        mirror_count = 0;
        mirror_age   = MAX_ROUTE_AGE_RST;

        // Hold reset, then release it once.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table after reset: lookup misses.
        add_beat(mk_req(OP_LOOKUP, 8'd0, 8'd0, 8'h00, 32'd0), 1'b1,
                 mk_rsp(1'b0, 8'd0, 8'h00, 32'd0, 1'b0, 1'b0, 5'd0));
        // Append with the extreme hop count and weakest signal.
        add_beat(mk_req(OP_UPDATE, 8'd0, 8'd255, 8'h80, 32'd0), 1'b1,
                 mk_rsp(1'b0, 8'd255, 8'h80, 32'd0, 1'b1, 1'b0, 5'd1));
        // Equal hops, equal signal: keep the entry.
        add_beat(mk_req(OP_UPDATE, 8'd0, 8'd255, 8'h80, 32'd5), 1'b1,
                 mk_rsp(1'b1, 8'd255, 8'h80, 32'd0, 1'b0, 1'b0, 5'd1));
        // Equal hops, stronger signal: overwrite.
        add_beat(mk_req(OP_UPDATE, 8'd0, 8'd255, 8'h7F, 32'd10), 1'b0, '0);
        // Fewer hops: overwrite.
        add_beat(mk_req(OP_UPDATE, 8'd0, 8'd0, 8'h80, 32'd20), 1'b0, '0);
        // More hops: keep.
        add_beat(mk_req(OP_UPDATE, 8'd0, 8'd1, 8'h7F, 32'd30), 1'b0, '0);
        // One ms short of the age limit: still fresh.
        add_beat(mk_req(OP_LOOKUP, 8'd0, 8'd9, 8'h11, 32'd300019), 1'b0, '0);
        // Exactly at the limit: stale, reported as not found.
        add_beat(mk_req(OP_LOOKUP, 8'd0, 8'd0, 8'h00, 32'd300020), 1'b1,
                 mk_rsp(1'b0, 8'd0, 8'h00, 32'd0, 1'b0, 1'b0, 5'd1));
        // Highest id at the top of the time range, then a lookup across the wrap.
        add_beat(mk_req(OP_UPDATE, 8'd255, 8'd7, 8'h00, 32'hFFFF_FFFF), 1'b0, '0);
        add_beat(mk_req(OP_LOOKUP, 8'd255, 8'hFF, 8'hFF, 32'd5), 1'b0, '0);
        // Fill the rest of the table.
        for (node_n = 1; node_n <= TABLE_ENTRIES - 2; node_n++)
            add_beat(mk_req(OP_UPDATE, 8'(node_n), 8'(node_n), 8'(node_n),
                            32'(100 + node_n)), 1'b0, '0);
        // Full table: a new id is dropped and flagged.
        add_beat(mk_req(OP_UPDATE, 8'd200, 8'd3, 8'h05, 32'd400), 1'b1,
                 mk_rsp(1'b0, 8'd0, 8'h00, 32'd0, 1'b0, 1'b1, 5'd16));
        // Full table: an existing id can still improve.
        add_beat(mk_req(OP_UPDATE, 8'd14, 8'd0, 8'h00, 32'd500), 1'b0, '0);
        add_beat(mk_req(OP_LOOKUP, 8'd200, 8'd0, 8'h00, 32'd500), 1'b1,
                 mk_rsp(1'b0, 8'd0, 8'h00, 32'd0, 1'b0, 1'b0, 5'd16));
        // Zero age limit: every route is stale.
        add_age(32'd0);
        add_beat(mk_req(OP_LOOKUP, 8'd255, 8'd0, 8'h00, 32'd5), 1'b1,
                 mk_rsp(1'b0, 8'd0, 8'h00, 32'd0, 1'b0, 1'b0, 5'd16));
        // Largest limit: an age of all ones is stale, one less is fresh.
        add_age(32'hFFFF_FFFF);
        add_beat(mk_req(OP_LOOKUP, 8'd14, 8'd0, 8'h00, 32'd499), 1'b0, '0);
        add_beat(mk_req(OP_LOOKUP, 8'd14, 8'd0, 8'h00, 32'd498), 1'b0, '0);
        // Smallest nonzero limit: only an age of zero is fresh.
        add_age(32'd1);
        add_beat(mk_req(OP_LOOKUP, 8'd14, 8'd0, 8'h00, 32'd500), 1'b0, '0);
        add_beat(mk_req(OP_LOOKUP, 8'd14, 8'd0, 8'h00, 32'd501), 1'b0, '0);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_AGE)
                write_age(directed_rows[k].age);
            else
                send_beat(directed_rows[k].req, directed_rows[k].typed,
                          directed_rows[k].rsp);
        end

        // Random phases, each with its own age limit. The write between
        // phases makes the sender pause until every response has come.
        phase_age[0] = MAX_ROUTE_AGE_RST;
        phase_age[1] = 32'd1000;
        phase_age[2] = 32'd1;
        phase_age[3] = 32'hFFFF_FFFF;
        phase_age[4] = 32'($urandom_range(50, 5000));
        ms_clock = 32'd1000;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_age(phase_age[phase]);
            for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
            begin
                beat.operation = ($urandom_range(0, 1) != 0) ? OP_LOOKUP : OP_UPDATE;
                // Mostly hit ids already in the table; the rest are random ids,
                // and the full table drops updates of new ones.
                if ($urandom_range(0, 3) != 0 && mirror_count > 0)
                begin
                    pick = $urandom_range(0, mirror_count - 1);
                    beat.node_id = route_mirror[pick].node;
                end
                else
                begin
                    pick = -1;
                    beat.node_id = 8'($urandom);
                end
                // Small hop counts make ties and improvements common.
                beat.hop_count = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                                            : 8'($urandom);
                beat.signal_strength = 8'($urandom);
                // Advance time slowly, with an occasional jump anywhere.
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    ms_clock = $urandom;
                else
                    ms_clock = ms_clock + 32'($urandom_range(0, 400));
                beat.now_ms = ms_clock;
                // Aim some lookups right at the freshness boundary.
                if (beat.operation == OP_LOOKUP && pick >= 0 && roll >= 80)
                    beat.now_ms = route_mirror[pick].stamp + mirror_age
                                  - 32'($urandom_range(0, 1));
                send_beat(beat, 1'b0, '0);
            end
        end

        // Drain: drop valid, wait for every response, then idle a little.
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
